FILE: rtl/delimiter_field_splitter_top_macros.svh
// Assertion macros for the delimiter field splitter
`ifndef DELIMITER_FIELD_SPLITTER_TOP_MACROS_SVH
`define DELIMITER_FIELD_SPLITTER_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset
`define DFS_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dfs check failed");

// Next-cycle implication, checked out of reset
`define DFS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dfs check failed");

`endif

FILE: rtl/dfs_pkg.sv
package dfs_pkg;

    localparam int MAX_DELIM    = 8;
    localparam int CHAR_W       = 8;
    localparam int DELIM_CHARS_W = 64;
    localparam int LEN_REG_W    = 4;
    localparam int CNT_W        = $clog2(MAX_DELIM + 1);
    localparam int IDX_W        = $clog2(MAX_DELIM);
    localparam int CFG_IDX_W    = 2;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DELIM_CHARS = 2'd0,
        CFG_DELIM_LEN   = 2'd1,
        CFG_GROUP_MODE  = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FLUSH,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [CHAR_W-1:0] out_char;
        logic              has_char;
        logic              segment_end;
        logic              batch_last;
    } t_result;

endpackage

FILE: rtl/dfs_in_if.sv
interface dfs_in_if;
    logic                      valid;
    logic                      ready;
    logic [dfs_pkg::CHAR_W-1:0] in_char;
    logic                      source_last;

    modport source (output valid, output in_char, output source_last, input ready);
    modport sink   (input valid, input in_char, input source_last, output ready);
endinterface

FILE: rtl/dfs_out_if.sv
interface dfs_out_if;
    logic                      valid;
    logic                      ready;
    logic [dfs_pkg::CHAR_W-1:0] out_char;
    logic                      has_char;
    logic                      segment_end;
    logic                      batch_last;

    modport source (output valid, output out_char, output has_char, output segment_end,
                    output batch_last, input ready);
    modport sink   (input valid, input out_char, input has_char, input segment_end,
                    input batch_last, output ready);
endinterface

FILE: rtl/delimiter_field_splitter_top.sv
// Channel  | Dir | Payload                                        | Transfer
// i_in     | in  | in_char[7:0], source_last                      | valid & ready
// o_out    | out | out_char[7:0], has_char, segment_end, batch_last | valid & ready
// i_cfg_*  | in  | i_cfg_idx[1:0], i_cfg_data[63:0]               | i_cfg_we
//
// An item is accepted, scanned, then retired with its last flag. Each released
// character takes its own scan step, except the release that empties the
// hold; end of source releases each held character in turn, then closes.
// The shared 8-way byte comparator is used once per scan cycle.
// Reset (synchronous, active low) restores registers to ',', length 1, no grouping.
// A stalled output holds the sequencer; input is taken only in the idle state.
`include "delimiter_field_splitter_top_macros.svh"

module delimiter_field_splitter_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    dfs_in_if.sink                               i_in,
    dfs_out_if.source                            o_out,
    input  logic                                 i_cfg_we,
    input  logic [dfs_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [dfs_pkg::DELIM_CHARS_W-1:0]    i_cfg_data
);

    localparam int CW = dfs_pkg::CHAR_W;
    localparam int NW = dfs_pkg::CNT_W;
    localparam int MD = dfs_pkg::MAX_DELIM;

    // configuration registers
    logic [dfs_pkg::DELIM_CHARS_W-1:0] r_delim;
    logic [dfs_pkg::LEN_REG_W-1:0]     r_len;
    logic                              r_group;

    // held partial-match characters and control state
    logic [CW-1:0]    r_held [MD];
    logic [NW-1:0]    r_cnt, n_cnt;
    logic             r_after, n_after;
    logic             r_open, n_open;
    logic             r_last, n_last;
    dfs_pkg::t_state  r_state, n_state;

    // pending result (lastness not yet known) and output register
    logic             r_pend_v, n_pend_v;
    dfs_pkg::t_result r_pend, n_pend;
    logic             r_out_v, n_out_v;
    dfs_pkg::t_result r_out, n_out;

    logic             do_append, do_shift;
    logic [NW-1:0]    act_len;
    logic             prefix;
    logic             out_free, can_emit;
    logic             emit;
    dfs_pkg::t_result res;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim <= dfs_pkg::DELIM_CHARS_W'(44);
            r_len   <= dfs_pkg::LEN_REG_W'(1);
            r_group <= 1'b0;
        end else if (i_cfg_we) begin
            case (dfs_pkg::t_cfg_idx'(i_cfg_idx))
                dfs_pkg::CFG_DELIM_CHARS: r_delim <= i_cfg_data;
                dfs_pkg::CFG_DELIM_LEN:   r_len   <= i_cfg_data[dfs_pkg::LEN_REG_W-1:0];
                dfs_pkg::CFG_GROUP_MODE:  r_group <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // clamp the delimiter length to 1..MAX_DELIM
    always_comb begin
        if (r_len == '0) begin
            act_len = NW'(1);
        end else if (r_len > dfs_pkg::LEN_REG_W'(MD)) begin
            act_len = NW'(MD);
        end else begin
            act_len = NW'(r_len);
        end
    end

    // shared comparator: held characters against the delimiter prefix
    always_comb begin
        prefix = (r_cnt <= act_len);
        for (int k = 0; k < MD; k++) begin
            if ((NW'(k) < r_cnt) && (r_held[k] != r_delim[CW*k +: CW])) begin
                prefix = 1'b0;
            end
        end
    end

    assign out_free = !r_out_v || o_out.ready;
    assign can_emit = !r_pend_v || out_free;

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_after   = r_after;
        n_open    = r_open;
        n_last    = r_last;
        do_append = 1'b0;
        do_shift  = 1'b0;
        emit      = 1'b0;
        res       = '0;
        n_pend_v  = r_pend_v;
        n_pend    = r_pend;
        n_out_v   = r_out_v && !o_out.ready;
        n_out     = r_out;

        case (r_state)
            dfs_pkg::S_IDLE: begin
                if (i_in.valid) begin
                    do_append = 1'b1;
                    n_cnt     = r_cnt + NW'(1);
                    n_last    = i_in.source_last;
                    n_state   = dfs_pkg::S_SCAN;
                end
            end
            dfs_pkg::S_SCAN: begin
                if (prefix && (r_cnt == act_len)) begin
                    // full delimiter match
                    if (!(r_after && r_group)) begin
                        if (can_emit) begin
                            emit    = 1'b1;
                            res.segment_end = 1'b1;
                            n_open  = 1'b0;
                            n_cnt   = '0;
                            n_after = r_group;
                            n_state = r_last ? dfs_pkg::S_FLUSH : dfs_pkg::S_DONE;
                        end
                    end else begin
                        n_cnt   = '0;
                        n_after = r_group;
                        n_state = r_last ? dfs_pkg::S_FLUSH : dfs_pkg::S_DONE;
                    end
                end else if (prefix) begin
                    n_state = r_last ? dfs_pkg::S_FLUSH : dfs_pkg::S_DONE;
                end else if (can_emit) begin
                    // failed partial match: release the oldest character
                    emit         = 1'b1;
                    res.out_char = r_held[0];
                    res.has_char = 1'b1;
                    do_shift     = 1'b1;
                    n_open       = 1'b1;
                    n_after      = 1'b0;
                    n_cnt        = r_cnt - NW'(1);
                    if (r_cnt == NW'(1)) begin
                        n_state = r_last ? dfs_pkg::S_FLUSH : dfs_pkg::S_DONE;
                    end
                end
            end
            dfs_pkg::S_FLUSH: begin
                // end of source: release everything, then close an open segment
                if (r_cnt != '0) begin
                    if (can_emit) begin
                        emit         = 1'b1;
                        res.out_char = r_held[0];
                        res.has_char = 1'b1;
                        do_shift     = 1'b1;
                        n_open       = 1'b1;
                        n_cnt        = r_cnt - NW'(1);
                    end
                end else if (!r_open || can_emit) begin
                    emit            = r_open;
                    res.segment_end = 1'b1;
                    n_open          = 1'b0;
                    n_after         = 1'b0;
                    n_state         = dfs_pkg::S_DONE;
                end
            end
            dfs_pkg::S_DONE: begin
                // retire the final result of this item with its last flag
                if (!r_pend_v) begin
                    n_state = dfs_pkg::S_IDLE;
                end else if (out_free) begin
                    n_out            = r_pend;
                    n_out.batch_last = 1'b1;
                    n_out_v          = 1'b1;
                    n_pend_v         = 1'b0;
                    n_state          = dfs_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = dfs_pkg::S_IDLE;
            end
        endcase

        // a new result pushes the pending one into the output register
        if (emit) begin
            if (r_pend_v) begin
                n_out   = r_pend;
                n_out_v = 1'b1;
            end
            n_pend_v = 1'b1;
            n_pend   = res;
        end
    end

    assign i_in.ready = (r_state == dfs_pkg::S_IDLE);

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= dfs_pkg::S_IDLE;
            r_cnt    <= '0;
            r_after  <= 1'b0;
            r_open   <= 1'b0;
            r_last   <= 1'b0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_after  <= n_after;
            r_open   <= n_open;
            r_last   <= n_last;
            r_pend_v <= n_pend_v;
            r_out_v  <= n_out_v;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
        r_out  <= n_out;
        if (do_append) begin
            r_held[r_cnt[dfs_pkg::IDX_W-1:0]] <= i_in.in_char;
        end else if (do_shift) begin
            for (int k = 0; k < MD - 1; k++) begin
                r_held[k] <= r_held[k+1];
            end
        end
    end

    assign o_out.valid       = r_out_v;
    assign o_out.out_char    = r_out.out_char;
    assign o_out.has_char    = r_out.has_char;
    assign o_out.segment_end = r_out.segment_end;
    assign o_out.batch_last  = r_out.batch_last;

    // no pending result survives past the end of an item
    `DFS_ASSERT_NOW(a_idle_no_pend, i_clk, i_rst_n, r_state == dfs_pkg::S_IDLE, !r_pend_v)
    // the scan step always has at least one held character
    `DFS_ASSERT_NOW(a_scan_nonempty, i_clk, i_rst_n, r_state == dfs_pkg::S_SCAN, r_cnt != '0)
    // retiring the pending result marks it as the last of its item
    `DFS_ASSERT_NEXT(a_done_last, i_clk, i_rst_n,
        r_state == dfs_pkg::S_DONE && r_pend_v && out_free, r_out_v && r_out.batch_last)

endmodule

FILE: tb/sv/delimiter_field_splitter_top_tb.sv
module delimiter_field_splitter_top_tb;
    import dfs_pkg::*;

    // Cycles allowed after the last result before the block counts as idle
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_ITEMS  = 450;
    // Index with no register behind it; writes to it must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    // Mirror of the splitter: holds its own registers and state and the
    // queue of results still to come
    class field_split_model;
        logic [DELIM_CHARS_W-1:0] delim_chars;
        logic [LEN_REG_W-1:0]     delim_len;
        logic                     grp;
        logic [CHAR_W-1:0]        held [MAX_DELIM];
        int unsigned              held_n;
        bit                       after_delim;
        bit                       seg_open;
        t_result                  want_q[$];
        t_result                  staged;
        bit                       staged_ok;
        int                       errors;

        function new();
            delim_chars = 64'd44;
            delim_len   = 4'd1;
            grp         = 1'b0;
            held_n      = 0;
            after_delim = 1'b0;
            seg_open    = 1'b0;
            staged_ok   = 1'b0;
            errors      = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [DELIM_CHARS_W-1:0] data);
            case (idx)
                CFG_DELIM_CHARS: delim_chars = data;
                CFG_DELIM_LEN:   delim_len   = data[LEN_REG_W-1:0];
                CFG_GROUP_MODE:  grp         = data[0];
                default: ;
            endcase
        endfunction

        function int outstanding();
            return want_q.size();
        endfunction

        // Results of one input are staged so the last one can carry batch_last
        function void emit(logic [CHAR_W-1:0] ch, bit has, bit seg_end);
            if (staged_ok) want_q.push_back(staged);
            staged.out_char    = ch;
            staged.has_char    = has;
            staged.segment_end = seg_end;
            staged.batch_last  = 1'b0;
            staged_ok          = 1'b1;
        endfunction

        function void release_oldest();
            int unsigned k;
            emit(held[0], 1'b1, 1'b0);
            seg_open    = 1'b1;
            after_delim = 1'b0;
            for (k = 1; k < held_n; k++) held[k-1] = held[k];
            held_n--;
        endfunction

        // Work out the results of one accepted character
        function void note_char(logic [CHAR_W-1:0] ch, bit last);
            int unsigned len;
            int unsigned n;
            int unsigned k;
            bit          prefix;
            if (held_n >= MAX_DELIM) release_oldest();
            held[held_n] = ch;
            held_n++;
            while (held_n > 0) begin
                len = (delim_len == 0) ? 1 : ((delim_len > MAX_DELIM) ? MAX_DELIM : delim_len);
                n = held_n;
                prefix = (n <= len);
                for (k = 0; prefix && k < n; k++)
                    if (held[k] != delim_chars[8*k +: 8]) prefix = 1'b0;
                if (prefix && n == len) begin
                    held_n = 0;
                    if (!(after_delim && grp)) begin
                        emit(8'h00, 1'b0, 1'b1);
                        seg_open = 1'b0;
                    end
                    after_delim = grp;
                    break;
                end
                if (prefix) break;
                release_oldest();
            end
            // end of source: flush, close the open segment, start over
            if (last) begin
                while (held_n > 0) release_oldest();
                if (seg_open) emit(8'h00, 1'b0, 1'b1);
                held_n      = 0;
                after_delim = 1'b0;
                seg_open    = 1'b0;
            end
            if (staged_ok) begin
                staged.batch_last = 1'b1;
                want_q.push_back(staged);
                staged_ok = 1'b0;
            end
        endfunction

        function void report(string field, logic [CHAR_W-1:0] want, logic [CHAR_W-1:0] got);
            errors++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
        endfunction

        // Compare one transferred result with the oldest expectation
        function void check_piece(t_result got);
            t_result want;
            if (want_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none actual %0h/%0b/%0b/%0b",
                         $time, got.out_char, got.has_char, got.segment_end,
                         got.batch_last);
                return;
            end
            want = want_q.pop_front();
            if (got.out_char !== want.out_char)
                report("out_char", want.out_char, got.out_char);
            if (got.has_char !== want.has_char)
                report("has_char", want.has_char, got.has_char);
            if (got.segment_end !== want.segment_end)
                report("segment_end", want.segment_end, got.segment_end);
            if (got.batch_last !== want.batch_last)
                report("batch_last", want.batch_last, got.batch_last);
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic                     i_cfg_we;
    logic [CFG_IDX_W-1:0]     i_cfg_idx;
    logic [DELIM_CHARS_W-1:0] i_cfg_data;

    dfs_in_if  in_ch();
    dfs_out_if out_ch();

    delimiter_field_splitter_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    field_split_model sb = new();

    int                       sent;
    bit                       tx_steady;
    bit                       rx_steady;
    logic [DELIM_CHARS_W-1:0] cur_chars;
    int                       cur_len;

    always #4 i_clk = ~i_clk;

    // Run limit
    initial begin
        #4000000;
        $display("delimiter_field_splitter_top test failed");
        $finish;
    end

    // Result sink: random stall after each transfer
    initial begin
        int      rx_hold;
        t_result got;
        rx_hold = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) begin
                got.out_char    = out_ch.out_char;
                got.has_char    = out_ch.has_char;
                got.segment_end = out_ch.segment_end;
                got.batch_last  = out_ch.batch_last;
                sb.check_piece(got);
                rx_hold = rx_steady ? 0 : $urandom_range(0, 11);
            end
            if (rx_hold > 0) begin
                rx_hold--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // One character transfer with a random lead-in gap; valid stays up
    // afterward so a zero gap gives back-to-back transfers
    task automatic send_char(logic [CHAR_W-1:0] ch, bit last);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.in_char     <= ch;
        in_ch.source_last <= last;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_char(ch, last);
        sent++;
    endtask

    task automatic send_str(string s, bit last_at_end);
        int i;
        for (i = 0; i < s.len(); i++)
            send_char(s[i], last_at_end && (i == s.len() - 1));
    endtask

    // Stop sending and wait until every expected result is in
    task automatic settle();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (sb.outstanding() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Leaves the write enable high; the caller lowers it
    task automatic reg_write(logic [CFG_IDX_W-1:0] idx, logic [DELIM_CHARS_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.set_reg(idx, data);
    endtask

    // Unused upper bits carry noise; the block must mask them
    task automatic write_regs(logic [DELIM_CHARS_W-1:0] chars, logic [LEN_REG_W-1:0] len,
                              bit grp);
        reg_write(CFG_DELIM_CHARS, chars);
        reg_write(CFG_DELIM_LEN, {$urandom, 28'($urandom), len});
        reg_write(CFG_GROUP_MODE, {$urandom, 31'($urandom), grp});
        reg_write(CFG_SPARE, {$urandom, $urandom});
        i_cfg_we  <= 1'b0;
        cur_chars = chars;
        cur_len   = (len == 0) ? 1 : ((len > MAX_DELIM) ? MAX_DELIM : len);
    endtask

    function automatic logic [DELIM_CHARS_W-1:0] make_delim(bit ab_only);
        logic [DELIM_CHARS_W-1:0] d;
        int k;
        for (k = 0; k < MAX_DELIM; k++)
            d[8*k +: 8] = (ab_only || $urandom_range(0, 1)) ? 8'(8'h61 + $urandom_range(0, 1))
                                                            : 8'($urandom_range(0, 255));
        return d;
    endfunction

    // Mostly delimiter characters, so partial matches happen often
    function automatic logic [CHAR_W-1:0] pick_char();
        case ($urandom_range(0, 3))
            0, 1:    return cur_chars[8*$urandom_range(0, cur_len - 1) +: 8];
            2:       return 8'(8'h61 + $urandom_range(0, 1));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // One source string built from delimiters, broken prefixes and filler
    task automatic send_string();
        logic [CHAR_W-1:0] chars_q[$];
        int reps;
        int j;
        int k;
        int plen;
        bit closes;
        if ($urandom_range(0, 9) == 0) begin
            // noise: raw bytes, end of source anywhere
            reps = $urandom_range(1, 6);
            for (j = 0; j < reps; j++)
                send_char(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
            return;
        end
        reps = $urandom_range(1, 6);
        for (j = 0; j < reps; j++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    for (k = 0; k < cur_len; k++) chars_q.push_back(cur_chars[8*k +: 8]);
                end
                4, 5: begin
                    if (cur_len > 1) begin
                        plen = $urandom_range(1, cur_len - 1);
                        for (k = 0; k < plen; k++) chars_q.push_back(cur_chars[8*k +: 8]);
                    end
                    chars_q.push_back(pick_char());
                end
                default: begin
                    repeat ($urandom_range(1, 3)) chars_q.push_back(pick_char());
                end
            endcase
        end
        closes = ($urandom_range(0, 6) != 0);
        for (k = 0; k < chars_q.size(); k++)
            send_char(chars_q[k], closes && (k == chars_q.size() - 1));
    endtask

    // Main sequence
    initial begin
        int phase;
        int phase_end;
        int goal;
        logic [DELIM_CHARS_W-1:0] chars;
        logic [LEN_REG_W-1:0]     len;
        sent      = 0;
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        cur_chars = 64'd44;
        cur_len   = 1;
        i_rst_n           <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.in_char     <= '0;
        in_ch.source_last <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_idx         <= CFG_DELIM_CHARS;
        i_cfg_data        <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // default comma delimiter: extreme bytes, empty segments, trailing delimiter
        send_char(8'h00, 1'b0);
        send_str(",,", 1'b0);
        send_char(8'hff, 1'b0);
        send_str(",", 1'b1);

        // three-char delimiter in group mode; aligned repeat ends on the last char
        settle();
        write_regs(64'h616261, 4'd3, 1'b1);
        send_str("xabaaba", 1'b1);
        // partial repeat at end of source is released
        send_str("abaab", 1'b1);
        // group mode dropped right after a delimiter
        send_str("aba", 1'b0);
        settle();
        write_regs(64'h616261, 4'd3, 1'b0);
        send_str("abaq", 1'b1);
        // delimiter shortened while a prefix is held
        send_str("ab", 1'b0);
        settle();
        write_regs(64'h62, 4'd1, 1'b0);
        send_str("c", 1'b1);

        // random phases, each with its own register setting
        goal  = sent + RANDOM_ITEMS;
        phase = 0;
        while (sent < goal) begin
            settle();
            case (phase)
                0: begin chars = '0; len = 4'd0; end
                1: begin chars = '1; len = 4'd15; end
                2: begin chars = make_delim(1'b1); len = 4'd8; end
                3: begin chars = make_delim(1'b1); len = 4'd1; end
                default: begin
                    chars = make_delim($urandom_range(0, 1));
                    len   = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15))
                                                        : 4'($urandom_range(1, 4));
                end
            endcase
            write_regs(chars, len, 1'($urandom_range(0, 1)));
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            phase_end = sent + $urandom_range(30, 70);
            while (sent < phase_end) send_string();
            phase++;
        end

        settle();
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("delimiter_field_splitter_top test passed");
        end else begin
            $display("delimiter_field_splitter_top test failed");
        end
        $finish;
    end

endmodule
